/* rtl/sha256_stream_hasher_top_assert.svh */
// Assertion macros used by the checker file of the SHA-256 stream hasher.
// No dependencies.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHS_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the following cycle.
`define SHS_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("assertion failed");

`endif

/* rtl/sha256_pkg.sv */
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// command and status structs shared by controller and datapath. No dependencies.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  // Sources for the byte written into the block buffer.
  localparam logic [1:0] SrcData = 2'd0;
  localparam logic [1:0] SrcPad = 2'd1;
  localparam logic [1:0] SrcZero = 2'd2;
  localparam logic [1:0] SrcLen = 2'd3;

  typedef struct packed {
    logic       wr_en;      // shift one byte into the block buffer, advance fill
    logic [1:0] wr_src;
    logic       count_bit;  // add eight to the bit count
    logic       start;      // load working registers, begin 64 rounds
    logic       round;      // run one round
    logic       finish;     // fold working registers into the hash
    logic       clear;      // return hash, fill and bit count to reset
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_done;
  } dp_stat_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage

/* rtl/sha256_datapath.sv */
// SHA-256 datapath: message schedule window that also collects the block bytes,
// working variables, hash words and counters. Depends on sha256_pkg.
module sha256_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::dp_cmd_t  cmd,
  input  logic [7:0]           data_byte,
  input  logic [2:0]           rd_index,
  output sha256_pkg::dp_stat_t stat,
  output sha256_pkg::word_t    rd_word
);
  import sha256_pkg::*;

  logic [5:0]  fill;
  logic [63:0] bit_count;
  word_t       hash [8];
  word_t       v [8];
  word_t       w [16];
  logic [5:0]  rnd;
  logic        round_done;
  logic [7:0]  wr_byte;
  logic [2:0]  len_sel;
  word_t       w_cur, s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  // Length bytes land at positions 56..63, most significant first.
  assign len_sel = 3'd7 - fill[2:0];

  always_comb begin
    case (cmd.wr_src)
      SrcData: wr_byte = data_byte;
      SrcPad:  wr_byte = PadByte;
      SrcZero: wr_byte = 8'h00;
      SrcLen:  wr_byte = bit_count[{len_sel, 3'b000} +: 8];
      default: wr_byte = 8'h00;
    endcase
  end

  // The schedule window shifts each round: w[0] is the word for this round.
  assign w_cur = w[0];
  assign s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign w_new = w[0] + s0 + w[9] + s1;

  assign big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1 = v[7] + big1 + ch + RoundK[rnd] + w_cur;
  assign big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2 = big0 + maj;

  // Block bytes shift in at the low end of the window, so after the 64th byte
  // the first byte of the block sits at the top of w[0].
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= {w[i][23:0], w[i+1][31:24]};
      end
      w[15] <= {w[15][23:0], wr_byte};
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        hash[i] <= StartH[i];
      end
      fill <= '0;
      bit_count <= '0;
      rnd <= '0;
      round_done <= 1'b0;
    end else begin
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
      if (cmd.wr_en) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_bit) begin
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.start) begin
        rnd <= '0;
        round_done <= 1'b0;
      end else if (cmd.round) begin
        rnd <= rnd + 6'd1;
        round_done <= (rnd == 6'd63);
      end
    end
  end

  assign stat.fill = fill;
  assign stat.round_done = round_done;
  assign rd_word = hash[rd_index];

endmodule

/* rtl/sha256_ctrl.sv */
// SHA-256 controller: sequences byte intake, padding, compressions and the
// digest output. Depends on sha256_pkg.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_has_byte,
  input  logic                 in_is_last,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_index,
  input  sha256_pkg::dp_stat_t stat,
  output sha256_pkg::dp_cmd_t  cmd
);
  import sha256_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun = 3'd1;
  localparam logic [2:0] StPadZero = 3'd2;
  localparam logic [2:0] StLen = 3'd3;
  localparam logic [2:0] StOut = 3'd4;
  localparam logic [2:0] StPadMark = 3'd5;

  logic [2:0] state, state_next;
  logic       final_pending, final_pending_next;  // zero padding resumes after this block
  logic       mark_pending, mark_pending_next;    // pad mark still owed after this block
  logic       len_block, len_block_next;          // block in flight holds the length
  logic [2:0] idx, idx_next;
  logic       cmd_started;

  assign in_ready = (state == StIdle);
  assign out_valid = (state == StOut);
  assign out_index = idx;

  always_comb begin
    state_next = state;
    final_pending_next = final_pending;
    mark_pending_next = mark_pending;
    len_block_next = len_block;
    idx_next = idx;
    cmd = '0;
    cmd.wr_src = SrcData;
    case (state)
      StIdle: begin
        if (in_valid) begin
          if (in_has_byte) begin
            cmd.wr_en = 1'b1;
            cmd.count_bit = 1'b1;
          end
          final_pending_next = 1'b0;
          mark_pending_next = in_is_last;
          len_block_next = 1'b0;
          if (in_has_byte && stat.fill == 6'd63) begin
            state_next = StRun;
          end else if (in_is_last) begin
            state_next = StPadMark;
          end
        end
      end
      StPadMark: begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = SrcPad;
        mark_pending_next = 1'b0;
        // A mark in the last byte fills the block before any zero.
        if (stat.fill == 6'd63) begin
          final_pending_next = 1'b1;
          state_next = StRun;
        end else begin
          final_pending_next = 1'b0;
          state_next = StPadZero;
        end
      end
      StPadZero: begin
        // Zero up to the length field, or to the block end when the mark
        // left no room for the length.
        if (stat.fill == LenPos && !final_pending) begin
          state_next = StLen;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_src = SrcZero;
          if (stat.fill == 6'd63) begin
            final_pending_next = 1'b1;
            state_next = StRun;
          end else if (stat.fill < LenPos) begin
            final_pending_next = 1'b0;
          end else begin
            final_pending_next = 1'b1;
          end
        end
      end
      StLen: begin
        cmd.wr_en = 1'b1;
        cmd.wr_src = SrcLen;
        if (stat.fill == 6'd63) begin
          len_block_next = 1'b1;
          state_next = StRun;
        end
      end
      StRun: begin
        // The first cycle here loads the working registers.
        if (!cmd_started) begin
          cmd.start = 1'b1;
        end else if (!stat.round_done) begin
          cmd.round = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          if (len_block) begin
            idx_next = '0;
            state_next = StOut;
          end else if (mark_pending) begin
            state_next = StPadMark;
          end else if (final_pending) begin
            state_next = StPadZero;
          end else begin
            state_next = StIdle;
          end
        end
      end
      StOut: begin
        if (out_ready) begin
          idx_next = idx + 3'd1;
          if (idx == 3'd7) begin
            cmd.clear = 1'b1;
            state_next = StIdle;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  // Tracks whether the load cycle of the current compression has passed.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_started <= 1'b0;
    end else begin
      cmd_started <= (state_next == StRun) && (state == StRun);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      final_pending <= 1'b0;
      mark_pending <= 1'b0;
      len_block <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      final_pending <= final_pending_next;
      mark_pending <= mark_pending_next;
      len_block <= len_block_next;
      idx <= idx_next;
    end
  end

endmodule

/* rtl/sha256_stream_hasher_top.sv */
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_datapath.
//
//   channel  dir  tdata                         tuser  tlast
//   s_axis   in   [7:0] data_byte, [8] has_byte  -      is_last
//   m_axis   out  [31:0] digest_word             [2:0] word_index  last_word
//
// A byte item is taken only in the idle state; a full block then runs the load,
// the 64 rounds and the fold in the single round unit while input waits. A last
// item pads byte by byte, runs one or two compressions, then shows eight words,
// one per accepted output cycle. Reset is synchronous; output stalls hold the
// word.
module sha256_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] has_byte, rest zero
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [2:0] idx;

  sha256_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_has_byte (s_axis_tdata[8]),
    .in_is_last  (s_axis_tlast),
    .in_ready    (s_axis_tready),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_index   (idx),
    .stat        (stat),
    .cmd         (cmd)
  );

  sha256_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (s_axis_tdata[7:0]),
    .rd_index  (idx),
    .stat      (stat),
    .rd_word   (m_axis_tdata)
  );

  assign m_axis_tuser = idx;
  assign m_axis_tlast = (idx == 3'd7);

endmodule

/* rtl/sha256_checker.sv */
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_top_assert.svh.
`include "sha256_stream_hasher_top_assert.svh"

module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  `SHS_ASSERT_IMPL(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  `SHS_ASSERT_IMPL(a_last_tag, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == 3'd7))
  `SHS_ASSERT_NEXT(a_index_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
  `SHS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind sha256_stream_hasher_top sha256_checker u_checker (.*);
